// ----- hdl/erp_pkg.sv -----
// ============================================================================
// erp_pkg
// Shared types and constants for the expander response parser.
// ============================================================================
package erp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 16;
    localparam int POS_W    = 6;
    localparam int MASK_W   = 16;
    localparam int TARGET_W = 2;
    localparam int SLOT_W   = 4;
    localparam int VALUE_W  = 16;

    // Command byte decode
    localparam logic [3:0]        CMD_LEN_MASK   = 4'hF;
    localparam int                CMD_SHORT_BIT  = 6;
    localparam int                CMD_CLRHI_BIT  = 5;

    // Frame addresses
    localparam logic [ADDR_W-1:0] ANALOG_ADDR    = 16'h001C;
    localparam logic [ADDR_W-1:0] GPIO_ADDR      = 16'h000A;

    // Analog frame layout
    localparam logic [POS_W-1:0]  POS_MASK_LO    = 6'd0;
    localparam logic [POS_W-1:0]  POS_MASK_HI    = 6'd1;
    localparam logic [POS_W-1:0]  POS_COUNTER    = 6'd3;
    localparam logic [POS_W-1:0]  POS_FIRST_PAIR = 6'd4;
    localparam logic [POS_W-1:0]  POS_SLOT_BASE  = 6'd6;
    localparam logic [POS_W-1:0]  SKIP_LIMIT     = 6'd36;

    // GPIO frame layout
    localparam logic [POS_W-1:0]  POS_PORT_C     = 6'd0;
    localparam logic [POS_W-1:0]  POS_PORT_B     = 6'd2;
    localparam logic [POS_W-1:0]  POS_PORT_A     = 6'd4;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [MASK_W-1:0]   t_mask;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [VALUE_W-1:0]  t_value;

    typedef enum logic [TARGET_W-1:0] {
        TGT_ANALOG = 2'd0,
        TGT_PORT_C = 2'd1,
        TGT_PORT_B = 2'd2,
        TGT_PORT_A = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        PH_CMD     = 2'd0,
        PH_ADDR_HI = 2'd1,
        PH_ADDR_LO = 2'd2,
        PH_DATA    = 2'd3
    } t_phase;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_SKIP = 1'b1
    } t_seq_state;

    // One step of the disabled-channel skip
    typedef struct packed {
        logic  run;
        t_pos  pos;
        t_mask mask;
    } t_skip_step;

endpackage

// ----- hdl/erp_if.sv -----
// ============================================================================
// erp_if
// Valid/ready channels for received bytes and decoded updates.
// ============================================================================
interface erp_rx_if;
    import erp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  chunk_last;

    modport source (output valid, output rx_byte, output chunk_last, input ready);
    modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface erp_upd_if;
    import erp_pkg::*;

    logic    valid;
    logic    ready;
    t_target target;
    t_slot   slot;
    t_value  value;
    logic    counter_valid;
    t_byte   sample_counter;

    modport source (output valid, output target, output slot, output value,
                    output counter_valid, output sample_counter, input ready);
    modport sink   (input valid, input target, input slot, input value,
                    input counter_valid, input sample_counter, output ready);
endinterface

// ----- hdl/erp_skip_unit.sv -----
// ============================================================================
// erp_skip_unit
// Shift/compare step shared by channel skipping and pair completion.
// ============================================================================
module erp_skip_unit (
    input  erp_pkg::t_pos       i_pos,
    input  erp_pkg::t_mask      i_mask,
    output erp_pkg::t_skip_step o_step
);
    import erp_pkg::*;

    // Continue while the current channel is disabled and the frame has room
    always_comb begin
        o_step.run  = !i_mask[0] && (i_pos < SKIP_LIMIT);
        o_step.pos  = i_pos + t_pos'(2);
        o_step.mask = i_mask >> 1;
    end

endmodule

// ----- hdl/expander_response_parser.sv -----
// ============================================================================
// expander_response_parser
// Byte-at-a-time decoder for the I/O expander response stream.
// ============================================================================
// Output: an update is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the update sink keeps up; an analog
// high byte then runs the shift/compare unit over the disabled channels (at
// most 16 skipped), and no further request is taken until that skip stops.
// Reset: synchronous active-low reset returns to command parsing with all
// address, position, mask and counter state cleared and no update pending.
module expander_response_parser (
    input  logic i_clk,
    input  logic i_rst_n,
    erp_rx_if.sink    i_rx,
    erp_upd_if.source o_upd
);
    import erp_pkg::*;

    t_seq_state r_seq, n_seq;
    t_phase     r_phase, n_phase;
    t_addr      r_addr, n_addr;
    t_pos       r_pos, n_pos;
    t_mask      r_mask, n_mask;
    t_byte      r_high, n_high;
    t_byte      r_counter, n_counter;

    logic       r_out_valid, n_out_valid;
    t_target    r_out_target, n_out_target;
    t_slot      r_out_slot, n_out_slot;
    t_value     r_out_value, n_out_value;
    logic       r_out_cv, n_out_cv;
    t_byte      r_out_cnt, n_out_cnt;

    t_skip_step w_step;
    logic       w_accept;
    logic       w_start_skip;
    t_pos       w_pos_inc;
    t_pos       w_slot_diff;
    t_slot      w_slot;
    t_byte      w_b;

    erp_skip_unit u_skip (
        .i_pos  (r_pos),
        .i_mask (r_mask),
        .o_step (w_step)
    );

    assign w_b          = i_rx.rx_byte;
    assign i_rx.ready   = (r_seq == SEQ_IDLE) && (!r_out_valid || o_upd.ready);
    assign w_accept     = i_rx.valid && i_rx.ready;
    assign w_pos_inc    = r_pos + t_pos'(1);
    assign w_slot_diff  = r_pos - POS_SLOT_BASE;
    assign w_slot       = (r_pos >= POS_SLOT_BASE) ? w_slot_diff[SLOT_W:1] : '0;
    assign w_start_skip = w_accept && (r_phase == PH_DATA) && (r_addr == ANALOG_ADDR)
                          && (r_pos >= POS_FIRST_PAIR) && !r_pos[0];

    // Sequencer next state: leave idle on a high byte, return when the skip stops
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_IDLE: if (w_start_skip) n_seq = SEQ_SKIP;
            SEQ_SKIP: if (!w_step.run)  n_seq = SEQ_IDLE;
            default:  n_seq = SEQ_IDLE;
        endcase
    end

    // Datapath and result register next values
    always_comb begin
        n_phase      = r_phase;
        n_addr       = r_addr;
        n_pos        = r_pos;
        n_mask       = r_mask;
        n_high       = r_high;
        n_counter    = r_counter;
        n_out_valid  = r_out_valid && !o_upd.ready;
        n_out_target = r_out_target;
        n_out_slot   = r_out_slot;
        n_out_value  = r_out_value;
        n_out_cv     = r_out_cv;
        n_out_cnt    = r_out_cnt;

        // Advance the skip one disabled channel per cycle
        if (r_seq == SEQ_SKIP && w_step.run) begin
            n_pos  = w_step.pos;
            n_mask = w_step.mask;
        end

        if (w_accept) begin
            unique case (r_phase)
                PH_CMD: begin
                    if ((w_b[3:0] & CMD_LEN_MASK) != 4'd0) begin
                        if (w_b[CMD_SHORT_BIT]) begin
                            if (w_b[CMD_CLRHI_BIT]) n_addr[ADDR_W-1:BYTE_W] = '0;
                            n_phase = PH_ADDR_LO;
                        end else begin
                            n_phase = PH_ADDR_HI;
                        end
                    end
                end
                PH_ADDR_HI: begin
                    n_addr  = {w_b, t_byte'(0)};
                    n_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_addr[BYTE_W-1:0] = w_b;
                    n_pos   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (r_addr == ANALOG_ADDR) begin
                        n_pos = w_pos_inc;
                        priority if (r_pos == POS_MASK_LO) begin
                            n_mask = {t_byte'(0), w_b};
                        end else if (r_pos == POS_MASK_HI) begin
                            n_mask = r_mask | {w_b, t_byte'(0)};
                        end else if (r_pos == POS_COUNTER) begin
                            n_counter = w_b;
                        end else if (r_pos >= POS_FIRST_PAIR && !r_pos[0]) begin
                            // Latch high byte; sequencer runs the skip from here
                            n_high = w_b;
                        end else if (r_pos >= POS_FIRST_PAIR) begin
                            // Complete a pair and drop the channel from the mask
                            n_mask       = w_step.mask;
                            n_out_valid  = 1'b1;
                            n_out_target = TGT_ANALOG;
                            n_out_slot   = w_slot;
                            n_out_value  = {r_high, w_b};
                            if (w_step.mask == '0) begin
                                n_phase   = PH_CMD;
                                n_out_cv  = 1'b1;
                                n_out_cnt = r_counter;
                            end else begin
                                n_out_cv  = 1'b0;
                                n_out_cnt = '0;
                            end
                        end
                    end else if (r_addr == GPIO_ADDR) begin
                        n_pos = w_pos_inc;
                        if (r_pos == POS_PORT_C || r_pos == POS_PORT_B
                            || r_pos == POS_PORT_A) begin
                            n_out_valid = 1'b1;
                            n_out_slot  = '0;
                            n_out_value = {t_byte'(0), w_b};
                            n_out_cv    = 1'b0;
                            n_out_cnt   = '0;
                        end
                        priority if (r_pos == POS_PORT_C) begin
                            n_out_target = TGT_PORT_C;
                        end else if (r_pos == POS_PORT_B) begin
                            n_out_target = TGT_PORT_B;
                        end else if (r_pos == POS_PORT_A) begin
                            n_out_target = TGT_PORT_A;
                            n_phase      = PH_CMD;
                        end
                    end else begin
                        // Consume bytes until a zero byte closes the frame
                        if (w_b == '0) n_phase = PH_CMD;
                    end
                end
                default: n_phase = PH_CMD;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_phase     <= PH_CMD;
            r_addr      <= '0;
            r_pos       <= '0;
            r_mask      <= '0;
            r_high      <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_addr      <= n_addr;
            r_pos       <= n_pos;
            r_mask      <= n_mask;
            r_high      <= n_high;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_target <= n_out_target;
        r_out_slot   <= n_out_slot;
        r_out_value  <= n_out_value;
        r_out_cv     <= n_out_cv;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_upd.valid          = r_out_valid;
    assign o_upd.target         = r_out_target;
    assign o_upd.slot           = r_out_slot;
    assign o_upd.value          = r_out_value;
    assign o_upd.counter_valid  = r_out_cv;
    assign o_upd.sample_counter = r_out_cnt;

endmodule

// ----- tb/sv/erp_decoder_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// erp_decoder_pkg
// Software decoder of the expander response stream. It tracks the parser
// state byte by byte, queues the updates that each request must cause and
// checks the updates that the parser delivers, field by field.
// ============================================================================
package erp_decoder_pkg;
    import erp_pkg::*;

    typedef struct packed {
        t_target target;
        t_slot   slot;
        t_value  value;
        logic    counter_valid;
        t_byte   sample_counter;
    } t_update;

    class response_decoder;
        t_phase     phase;
        logic [3:0] len_nibble;
        t_addr      addr;
        t_pos       pos;
        t_mask      mask;
        t_byte      high_byte;
        t_byte      counter;
        t_update    due_updates[$];
        int         errors;

        function new();
            phase      = PH_CMD;
            len_nibble = '0;
            addr       = '0;
            pos        = '0;
            mask       = '0;
            high_byte  = '0;
            counter    = '0;
            errors     = 0;
        endfunction

        function void push_update(t_target tg, t_slot s, t_value v, logic cv, t_byte c);
            t_update upd;
            upd.target         = tg;
            upd.slot           = s;
            upd.value          = v;
            upd.counter_valid  = cv;
            upd.sample_counter = c;
            due_updates.push_back(upd);
        endfunction

        // Analog frame: mask, skipped byte, counter, then high/low pairs
        function void analog_byte(t_byte b);
            int unsigned p;
            logic        done;
            t_slot       s;
            p = pos;
            if (p == POS_MASK_LO) begin
                mask = {8'h00, b};
            end else if (p == POS_MASK_HI) begin
                mask[15:8] = b;
            end else if (p == POS_COUNTER) begin
                counter = b;
            end else if (p > POS_COUNTER && (p % 2) == 0) begin
                // Latch the high byte, then step over disabled channels
                high_byte = b;
                p++;
                while (!mask[0] && p < SKIP_LIMIT) begin
                    p    = p + 2;
                    mask = mask >> 1;
                end
                pos = t_pos'(p);
                return;
            end else if (p > POS_COUNTER) begin
                s    = (p >= POS_SLOT_BASE) ? t_slot'((p - POS_SLOT_BASE) / 2) : t_slot'(0);
                mask = mask >> 1;
                done = (mask == '0);
                push_update(TGT_ANALOG, s, {high_byte, b}, done, done ? counter : 8'h00);
                if (done) begin
                    phase = PH_CMD;
                end
            end
            pos = t_pos'(p + 1);
        endfunction

        // GPIO read: ports C, B and A at even positions, A closes the frame
        function void gpio_byte(t_byte b);
            if (pos == POS_PORT_C) begin
                push_update(TGT_PORT_C, '0, {8'h00, b}, 1'b0, 8'h00);
            end else if (pos == POS_PORT_B) begin
                push_update(TGT_PORT_B, '0, {8'h00, b}, 1'b0, 8'h00);
            end else if (pos == POS_PORT_A) begin
                push_update(TGT_PORT_A, '0, {8'h00, b}, 1'b0, 8'h00);
                phase = PH_CMD;
            end
            pos = pos + 1'b1;
        endfunction

        // Advance the decoder by one accepted request
        function void take_byte(t_byte b);
            case (phase)
                PH_CMD: begin
                    len_nibble = b[3:0] & CMD_LEN_MASK;
                    if (len_nibble != '0) begin
                        if (b[CMD_SHORT_BIT]) begin
                            if (b[CMD_CLRHI_BIT]) begin
                                addr[15:8] = 8'h00;
                            end
                            phase = PH_ADDR_LO;
                        end else begin
                            phase = PH_ADDR_HI;
                        end
                    end
                end
                PH_ADDR_HI: begin
                    addr  = {b, 8'h00};
                    phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    addr[7:0] = b;
                    phase     = PH_DATA;
                    pos       = '0;
                end
                default: begin
                    if (addr == ANALOG_ADDR) begin
                        analog_byte(b);
                    end else if (addr == GPIO_ADDR) begin
                        gpio_byte(b);
                    end else if (b == 8'h00) begin
                        phase = PH_CMD;
                    end
                end
            endcase
        endfunction

        // Compare a delivered update with the oldest one due
        function void match_update(t_update seen);
            t_update want;
            if (due_updates.size() == 0) begin
                $display("%0t: unexpected update target=%0d slot=%0d value=%h cv=%b cnt=%h",
                         $time, seen.target, seen.slot, seen.value, seen.counter_valid,
                         seen.sample_counter);
                errors++;
                return;
            end
            want = due_updates.pop_front();
            if (seen.target !== want.target) begin
                $display("%0t: target expected %0d actual %0d", $time, want.target, seen.target);
                errors++;
            end
            if (seen.slot !== want.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, want.slot, seen.slot);
                errors++;
            end
            if (seen.value !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, seen.value);
                errors++;
            end
            if (seen.counter_valid !== want.counter_valid) begin
                $display("%0t: counter_valid expected %b actual %b", $time,
                         want.counter_valid, seen.counter_valid);
                errors++;
            end
            if (seen.sample_counter !== want.sample_counter) begin
                $display("%0t: sample_counter expected %h actual %h", $time,
                         want.sample_counter, seen.sample_counter);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/expander_response_parser_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// expander_response_parser_test
// Drives framed and noisy byte streams into the response parser with bursty
// requests and a stalling update sink, and checks every update against a
// byte-level decoder of the same protocol.
// ============================================================================
module expander_response_parser_test;
    import erp_pkg::*;
    import erp_decoder_pkg::*;

    localparam int RANDOM_BYTES = 500;
    localparam int DRAIN_CYCLES = 32;

    logic i_clk   = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    logic [1:0] sink_mode = 2'd0;
    logic [5:0] sink_tick = 6'd0;

    int unsigned burst_left = 0;
    int unsigned sent_bytes = 0;

    response_decoder decoder;

    erp_rx_if  rx_bus();
    erp_upd_if upd_bus();

    expander_response_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_upd   (upd_bus)
    );

    assign upd_bus.ready = sink_ready;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the update sink: always ready, periodic, or random, switching modes
    always @(posedge i_clk) begin
        if (sink_tick == '0) begin
            sink_mode <= 2'($urandom_range(2, 0));
        end
        sink_tick <= sink_tick - 1'b1;
        case (sink_mode)
            2'd0:    sink_ready <= 1'b1;
            2'd1:    sink_ready <= (sink_tick[1:0] != 2'b11);
            default: sink_ready <= ($urandom_range(3, 0) != 0);
        endcase
    end

    // Check every update taken by the sink
    always @(posedge i_clk) begin
        t_update seen;
        if (upd_bus.valid && upd_bus.ready) begin
            seen.target         = upd_bus.target;
            seen.slot           = upd_bus.slot;
            seen.value          = upd_bus.value;
            seen.counter_valid  = upd_bus.counter_valid;
            seen.sample_counter = upd_bus.sample_counter;
            decoder.match_update(seen);
        end
    end

    // Send one request; idle between bursts of random length
    task automatic send_request(input t_byte b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(5, 1);
            burst_left = ($urandom_range(7, 0) == 0) ? 60 : $urandom_range(12, 1);
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        rx_bus.valid      <= 1'b1;
        rx_bus.rx_byte    <= b;
        rx_bus.chunk_last <= last;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        decoder.take_byte(b);
        sent_bytes++;
    endtask

    task automatic send_random(input t_byte b);
        send_request(b, $urandom_range(3, 0) == 0);
    endtask

    // Issue a command byte and the address bytes for address a
    task automatic send_address(input t_addr a);
        t_byte       cmd;
        int unsigned how;
        cmd      = t_byte'($urandom);
        cmd[3:0] = 4'($urandom_range(15, 1));
        how      = $urandom_range(2, 0);
        if (how == 1 && a[15:8] != decoder.addr[15:8]) how = 0;
        if (how == 2 && a[15:8] != 8'h00) how = 0;
        case (how)
            0: begin
                cmd[CMD_SHORT_BIT] = 1'b0;
                send_random(cmd);
                send_random(a[15:8]);
            end
            1: begin
                cmd[CMD_SHORT_BIT] = 1'b1;
                cmd[CMD_CLRHI_BIT] = 1'b0;
                send_random(cmd);
            end
            default: begin
                cmd[CMD_SHORT_BIT] = 1'b1;
                cmd[CMD_CLRHI_BIT] = 1'b1;
                send_random(cmd);
            end
        endcase
        send_random(a[7:0]);
    endtask

    task automatic send_analog_frame();
        t_mask       m;
        int unsigned pairs;
        send_address(ANALOG_ADDR);
        case ($urandom_range(5, 0))
            0:       m = '0;
            1:       m = '1;
            2:       m = t_mask'(1) << $urandom_range(15, 0);
            3:       m = t_mask'($urandom & $urandom & $urandom);
            default: m = t_mask'($urandom);
        endcase
        pairs = (m == '0) ? 1 : $countones(m);
        send_random(m[7:0]);
        send_random(m[15:8]);
        send_random(t_byte'($urandom));
        send_random(t_byte'($urandom));
        repeat (2 * pairs) send_random(t_byte'($urandom));
    endtask

    task automatic send_gpio_frame();
        send_address(GPIO_ADDR);
        repeat (5) send_random(t_byte'($urandom));
    endtask

    task automatic send_other_frame();
        t_addr a;
        a = t_addr'($urandom);
        if ($urandom_range(3, 0) == 0) a[15:8] = decoder.addr[15:8];
        if (a == ANALOG_ADDR || a == GPIO_ADDR) a[8] = ~a[8];
        send_address(a);
        repeat ($urandom_range(6, 0)) send_random(t_byte'($urandom_range(255, 1)));
        send_random(8'h00);
    endtask

    // Drop random bytes in, then run the parser back to command parsing
    task automatic send_noise();
        t_byte b;
        repeat ($urandom_range(8, 1)) begin
            b = t_byte'($urandom);
            if ($urandom_range(3, 0) == 0) b[3:0] = 4'h0;
            send_random(b);
        end
        while (decoder.phase != PH_CMD) begin
            b = t_byte'($urandom);
            if (decoder.phase == PH_DATA && decoder.addr != ANALOG_ADDR &&
                decoder.addr != GPIO_ADDR && $urandom_range(1, 0) == 0) begin
                b = 8'h00;
            end
            send_random(b);
        end
    endtask

    task automatic run_directed();
        // Zero-length commands are dropped
        send_request(8'h00, 1'b0);
        send_request(8'hF0, 1'b1);
        // GPIO read with a long address
        send_request(8'h05, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h0A, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h12, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h34, 1'b0);
        send_request(8'hA5, 1'b1);
        // Analog frame, short address clearing the high byte, channels 0 and 15
        send_request(8'h61, 1'b0);
        send_request(8'h1C, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'h33, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        // Analog frame with an empty enable mask, short address keeping high byte
        send_request(8'h41, 1'b0);
        send_request(8'h1C, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h7E, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b1);
        // Bit 5 without bit 6 takes a long address; other address ends on zero
        send_request(8'h2F, 1'b0);
        send_request(8'hAB, 1'b0);
        send_request(8'h1C, 1'b0);
        send_request(8'h55, 1'b0);
        send_request(8'h00, 1'b1);
        // Short address keeps high byte 0xAB, so 0xAB0A is not a GPIO read
        send_request(8'h4F, 1'b0);
        send_request(8'h0A, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'h00, 1'b1);
    endtask

    initial begin
        int unsigned start;
        decoder = new();
        rx_bus.valid      <= 1'b0;
        rx_bus.rx_byte    <= '0;
        rx_bus.chunk_last <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Mostly well-formed frames with random content, some noise
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3: send_analog_frame();
                4, 5:       send_gpio_frame();
                6, 7:       send_other_frame();
                default:    send_noise();
            endcase
        end

        // Drain the outstanding updates
        rx_bus.valid <= 1'b0;
        while (decoder.due_updates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoder.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
